[rtl/kill_ring_byte_store_assert.svh]
// ----------------------------------------------------------------------------
// kill_ring_byte_store_assert.svh
// Assertion macros for the kill ring RTL.
// ----------------------------------------------------------------------------
`ifndef KILL_RING_BYTE_STORE_ASSERT_SVH
`define KILL_RING_BYTE_STORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define KRBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/krbs_pkg.sv]
// ----------------------------------------------------------------------------
// krbs_pkg
// Sizes, operation codes and shared types of the kill ring byte store.
// ----------------------------------------------------------------------------
package krbs_pkg;

	localparam int RING_ENTRIES = 64;
	localparam int ENTRY_BYTES  = 1024;

	localparam int SLOT_W  = $clog2(RING_ENTRIES);
	localparam int CNT_W   = $clog2(RING_ENTRIES + 1);
	localparam int OFF_W   = $clog2(ENTRY_BYTES);
	localparam int LEN_W   = $clog2(ENTRY_BYTES + 1);
	localparam int ADDR_W  = SLOT_W + OFF_W;
	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 10;

	localparam logic [OP_W-1:0] OP_NEW_KILL    = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND      = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT      = 3'd2;
	localparam logic [OP_W-1:0] OP_READ        = 3'd3;
	localparam logic [OP_W-1:0] OP_YANK_NEWEST = 3'd4;
	localparam logic [OP_W-1:0] OP_YANK_OLDER  = 3'd5;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
		entry_t            wr_entry;
	} meta_req_t;

endpackage

[rtl/krbs_ram.sv]
// ----------------------------------------------------------------------------
// krbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module krbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/krbs_meta.sv]
// ----------------------------------------------------------------------------
// krbs_meta
// Per-entry start/length table: RAM plus valid bits so reset reads as zero.
// ----------------------------------------------------------------------------
module krbs_meta (
	input  logic               clk,
	input  logic               arst_n,
	input  krbs_pkg::meta_req_t req,
	output krbs_pkg::entry_t    rd_entry
);
	import krbs_pkg::*;

	logic [RING_ENTRIES-1:0] valid_q;
	logic                    rd_valid_q;
	entry_t                  ram_rdata;

	krbs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(RING_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_slot),
		.wdata (req.wr_entry),
		.re    (req.rd_en),
		.raddr (req.rd_slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_slot] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_slot];
			end
		end
	end

	assign rd_entry = rd_valid_q ? ram_rdata : '0;

endmodule

[rtl/kill_ring_byte_store.sv]
// ----------------------------------------------------------------------------
// kill_ring_byte_store
// Ring of kill entries, each a circular double-ended byte buffer.
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   operation, data_byte, index             start && !busy
// result    read_byte, read_hit, status,            done (one cycle)
//           yank_entry, entries_used
//
// A request reads its entry's start/length from the metadata RAM, then
// updates it and the byte RAM (state META); a hitting read then reads the
// byte RAM (state BYTE); done is registered. busy covers the whole request;
// the next request can be accepted in the done cycle. Reset needs no
// clearing pass: metadata entries carry valid bits. Results cannot be stalled.
// ----------------------------------------------------------------------------
module kill_ring_byte_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [krbs_pkg::OP_W-1:0]    operation,
	input  logic [krbs_pkg::BYTE_W-1:0]  data_byte,
	input  logic [krbs_pkg::INDEX_W-1:0] index,
	output logic                         done,
	output logic [krbs_pkg::BYTE_W-1:0]  read_byte,
	output logic                         read_hit,
	output logic                         status,
	output logic [krbs_pkg::SLOT_W-1:0]  yank_entry,
	output logic [krbs_pkg::CNT_W-1:0]   entries_used
);
	import krbs_pkg::*;

	`include "kill_ring_byte_store_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_META = 2'd1;
	localparam logic [1:0] ST_BYTE = 2'd2;

	logic [1:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [BYTE_W-1:0]  data_q;
	logic [INDEX_W-1:0] idx_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  head_q;
	logic [SLOT_W-1:0]  yank_q;
	logic [CNT_W-1:0]   used_q;
	logic               done_q;
	logic [BYTE_W-1:0]  read_byte_q;
	logic               read_hit_q;
	logic               status_q;

	logic              accept;
	meta_req_t         meta_req;
	entry_t            ent;
	logic              is_ins;
	logic              full;
	logic              hit;
	logic              finish;
	logic [OFF_W-1:0]  start_dec;
	logic [OFF_W-1:0]  back_off;
	logic [OFF_W-1:0]  rd_off;
	logic [SLOT_W-1:0] head_inc;
	logic [SLOT_W-1:0] head_new;
	logic [SLOT_W-1:0] used_m1;
	logic [SLOT_W-1:0] oldest;
	logic [SLOT_W-1:0] yank_dec;
	logic              byte_we;
	logic [ADDR_W-1:0] byte_waddr;
	logic              byte_re;
	logic [ADDR_W-1:0] byte_raddr;
	logic [BYTE_W-1:0] byte_rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	krbs_meta u_meta (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (meta_req),
		.rd_entry (ent)
	);

	krbs_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_ENTRIES * ENTRY_BYTES)
	) u_bytes (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (data_q),
		.re    (byte_re),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	always_comb begin
		is_ins    = op_q inside {OP_APPEND, OP_INSERT};
		full      = (ent.len >= LEN_W'(ENTRY_BYTES));
		hit       = (LEN_W'(idx_q) < ent.len);
		start_dec = ent.start - OFF_W'(1);
		back_off  = ent.start + ent.len[OFF_W-1:0];
		rd_off    = ent.start + OFF_W'(idx_q);

		head_inc = (head_q == SLOT_W'(RING_ENTRIES - 1)) ? '0 : head_q + SLOT_W'(1);
		head_new = (used_q != '0) ? head_inc : head_q;

		used_m1  = SLOT_W'(used_q - CNT_W'(1));
		oldest   = (head_q >= used_m1) ? head_q - used_m1
			: SLOT_W'(CNT_W'(head_q) + CNT_W'(RING_ENTRIES) - CNT_W'(used_m1));
		yank_dec = (yank_q == '0) ? SLOT_W'(RING_ENTRIES - 1) : yank_q - SLOT_W'(1);

		finish = (state_q == ST_BYTE) || ((state_q == ST_META) && !((op_q == OP_READ) && hit));

		meta_req.rd_en    = accept;
		meta_req.rd_slot  = (operation == OP_READ) ? yank_q : head_q;
		meta_req.wr_en    = 1'b0;
		meta_req.wr_slot  = slot_q;
		meta_req.wr_entry = ent;
		byte_we    = 1'b0;
		byte_waddr = {slot_q, back_off};
		byte_re    = 1'b0;
		byte_raddr = {slot_q, rd_off};

		if (state_q == ST_META) begin
			case (op_q)
				OP_NEW_KILL: begin
					meta_req.wr_en    = 1'b1;
					meta_req.wr_slot  = head_new;
					meta_req.wr_entry = '0;
				end
				OP_APPEND: begin
					meta_req.wr_en        = !full;
					meta_req.wr_entry.len = ent.len + LEN_W'(1);
					byte_we               = !full;
				end
				OP_INSERT: begin
					meta_req.wr_en          = !full;
					meta_req.wr_entry.start = start_dec;
					meta_req.wr_entry.len   = ent.len + LEN_W'(1);
					byte_we                 = !full;
					byte_waddr              = {slot_q, start_dec};
				end
				OP_READ: begin
					byte_re = hit;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			yank_q  <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					state_q <= finish ? ST_IDLE : ST_BYTE;
					case (op_q)
						OP_NEW_KILL: begin
							head_q <= head_new;
							yank_q <= head_new;
							if (used_q < CNT_W'(RING_ENTRIES)) begin
								used_q <= used_q + CNT_W'(1);
							end
						end
						OP_YANK_NEWEST: begin
							yank_q <= head_q;
						end
						OP_YANK_OLDER: begin
							if (used_q == '0 || yank_q == oldest) begin
								yank_q <= head_q;
							end else begin
								yank_q <= yank_dec;
							end
						end
						default: begin
						end
					endcase
				end
				ST_BYTE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			data_q <= data_byte;
			idx_q  <= index;
			slot_q <= meta_req.rd_slot;
		end
		if (state_q == ST_BYTE) begin
			read_byte_q <= byte_rdata;
			read_hit_q  <= 1'b1;
			status_q    <= 1'b0;
		end else if (finish) begin
			read_byte_q <= '0;
			read_hit_q  <= 1'b0;
			status_q    <= is_ins && full;
		end
	end

	assign done         = done_q;
	assign read_byte    = read_byte_q;
	assign read_hit     = read_hit_q;
	assign status       = status_q;
	assign yank_entry   = yank_q;
	assign entries_used = used_q;

	`KRBS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a request is in flight")
	`KRBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`KRBS_ASSERT_NOW(a_used_max, 1'b1, used_q <= CNT_W'(RING_ENTRIES), "entry count past ring size")
	`KRBS_ASSERT_NOW(a_hit_ok, done && read_hit, !status, "read hit together with reject status")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for kill_ring_byte_store. Requests go in over the
// start/busy handshake in random bursts. Each accepted request runs through a
// behavioral copy of the kill ring, and the expected result is queued. Every
// done strobe is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module tb;
	import krbs_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 300;

	typedef struct {
		logic [BYTE_W-1:0] rbyte;
		logic              hit;
		logic              rejected;
		logic [SLOT_W-1:0] yank;
		logic [CNT_W-1:0]  used;
	} ring_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OP_W-1:0]     operation = '0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic                busy;
	logic                done;
	logic [BYTE_W-1:0]   read_byte;
	logic                read_hit;
	logic                status;
	logic [SLOT_W-1:0]   yank_entry;
	logic [CNT_W-1:0]    entries_used;

	// kill ring mirror
	bit [BYTE_W-1:0] ring_bytes [RING_ENTRIES*ENTRY_BYTES];
	bit [OFF_W-1:0]  ent_start [RING_ENTRIES];
	bit [LEN_W-1:0]  ent_len [RING_ENTRIES];
	bit [SLOT_W-1:0] head_q;
	bit [CNT_W-1:0]  used_q;
	bit [SLOT_W-1:0] yank_q;

	ring_result_t ring_results_due[$];
	int err_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	kill_ring_byte_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.data_byte(data_byte),
		.index(index),
		.done(done),
		.read_byte(read_byte),
		.read_hit(read_hit),
		.status(status),
		.yank_entry(yank_entry),
		.entries_used(entries_used)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic ring_result_t kill_ring_apply(logic [OP_W-1:0] op,
			logic [BYTE_W-1:0] data, logic [INDEX_W-1:0] idx);
		ring_result_t res;
		int h;
		int y;
		int oldest;
		res = '{default: '0};
		h = head_q;
		case (op)
			OP_NEW_KILL: begin
				if (used_q > 0)
					h = (h + 1) % RING_ENTRIES;
				head_q = SLOT_W'(h);
				ent_start[h] = '0;
				ent_len[h] = '0;
				if (used_q < RING_ENTRIES)
					used_q = CNT_W'(used_q + 1);
				yank_q = SLOT_W'(h);
			end
			OP_APPEND: begin
				if (ent_len[h] >= ENTRY_BYTES) begin
					res.rejected = 1'b1;
				end else begin
					ring_bytes[h*ENTRY_BYTES + (ent_start[h] + ent_len[h]) % ENTRY_BYTES] = data;
					ent_len[h] = LEN_W'(ent_len[h] + 1);
				end
			end
			OP_INSERT: begin
				if (ent_len[h] >= ENTRY_BYTES) begin
					res.rejected = 1'b1;
				end else begin
					ent_start[h] = OFF_W'((ent_start[h] + ENTRY_BYTES - 1) % ENTRY_BYTES);
					ring_bytes[h*ENTRY_BYTES + ent_start[h]] = data;
					ent_len[h] = LEN_W'(ent_len[h] + 1);
				end
			end
			OP_READ: begin
				y = yank_q;
				if (idx < ent_len[y]) begin
					res.hit = 1'b1;
					res.rbyte = ring_bytes[y*ENTRY_BYTES + (ent_start[y] + idx) % ENTRY_BYTES];
				end
			end
			OP_YANK_NEWEST: yank_q = SLOT_W'(h);
			OP_YANK_OLDER: begin
				if (used_q == 0) begin
					yank_q = SLOT_W'(h);
				end else begin
					oldest = (h + RING_ENTRIES - (used_q - 1)) % RING_ENTRIES;
					y = yank_q;
					yank_q = SLOT_W'((y == oldest) ? h : (y + RING_ENTRIES - 1) % RING_ENTRIES);
				end
			end
			default: ;
		endcase
		res.yank = yank_q;
		res.used = used_q;
		return res;
	endfunction

	// mostly an index inside the yank entry, otherwise anything
	function automatic logic [INDEX_W-1:0] pick_index();
		int len;
		len = ent_len[yank_q];
		if (len > 0 && $urandom_range(0, 4) != 0)
			return INDEX_W'($urandom_range(0, len - 1));
		return INDEX_W'($urandom_range(0, 2**INDEX_W - 1));
	endfunction

	task automatic report(string what, int got, int want);
		err_count++;
		if (err_count <= 40)
			$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && done) begin
			if (ring_results_due.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = ring_results_due.pop_front();
				if (read_byte !== want.rbyte) report("read_byte", read_byte, want.rbyte);
				if (read_hit !== want.hit) report("read_hit", read_hit, want.hit);
				if (status !== want.rejected) report("status", status, want.rejected);
				if (yank_entry !== want.yank) report("yank_entry", yank_entry, want.yank);
				if (entries_used !== want.used)
					report("entries_used", entries_used, want.used);
			end
		end
	end

	// bursts of back-to-back requests with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_req(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
			logic [INDEX_W-1:0] idx);
		pace();
		operation <= op;
		data_byte <= data;
		index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		ring_results_due.push_back(kill_ring_apply(op, data, idx));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (ring_results_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_req(OP_SPARE_6, 8'h00, 10'd0);
		send_req(OP_SPARE_7, 8'hFF, 10'd1023);
		send_req(OP_YANK_OLDER, 8'h00, 10'd0);	// empty ring
		send_req(OP_APPEND, 8'h00, 10'd0);	// before any kill
		send_req(OP_INSERT, 8'hFF, 10'd0);
		send_req(OP_READ, 8'h00, 10'd0);
		send_req(OP_READ, 8'h00, 10'd1);
		send_req(OP_READ, 8'h00, 10'd2);
		send_req(OP_READ, 8'h00, 10'd1023);
		send_req(OP_NEW_KILL, 8'h00, 10'd0);
		send_req(OP_READ, 8'h00, 10'd0);
		send_req(OP_APPEND, 8'h5A, 10'd0);
		send_req(OP_INSERT, 8'hA5, 10'd0);
		send_req(OP_APPEND, 8'hFF, 10'd0);
		send_req(OP_READ, 8'h00, 10'd2);
		send_req(OP_NEW_KILL, 8'h00, 10'd0);
		send_req(OP_INSERT, 8'h01, 10'd0);
		send_req(OP_YANK_OLDER, 8'h00, 10'd0);
		send_req(OP_READ, 8'h00, 10'd1);
		send_req(OP_YANK_OLDER, 8'h00, 10'd0);	// oldest wraps to newest
		send_req(OP_YANK_OLDER, 8'h00, 10'd0);
		send_req(OP_YANK_NEWEST, 8'h00, 10'd0);
		send_req(OP_READ, 8'h00, 10'd0);
	endtask

	task automatic test_entry_fill();
		send_req(OP_NEW_KILL, BYTE_W'($urandom), INDEX_W'($urandom));
		while (ent_len[head_q] < ENTRY_BYTES)
			send_req($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, BYTE_W'($urandom),
				INDEX_W'($urandom));
		send_req(OP_YANK_NEWEST, BYTE_W'($urandom), INDEX_W'($urandom));
		send_req(OP_APPEND, BYTE_W'($urandom), INDEX_W'($urandom));
		send_req(OP_INSERT, BYTE_W'($urandom), INDEX_W'($urandom));
		send_req(OP_READ, BYTE_W'($urandom), 10'd0);
		send_req(OP_READ, BYTE_W'($urandom), INDEX_W'(ENTRY_BYTES - 1));
		repeat (16) send_req(OP_READ, BYTE_W'($urandom), pick_index());
	endtask

	task automatic test_ring_wrap();
		repeat (RING_ENTRIES + 6) begin
			send_req(OP_NEW_KILL, BYTE_W'($urandom), INDEX_W'($urandom));
			send_req(OP_APPEND, BYTE_W'($urandom), INDEX_W'($urandom));
		end
		repeat (RING_ENTRIES + 4) begin
			send_req(OP_YANK_OLDER, BYTE_W'($urandom), INDEX_W'($urandom));
			send_req(OP_READ, BYTE_W'($urandom), 10'd0);
			send_req(OP_READ, BYTE_W'($urandom), 10'd1);
		end
		send_req(OP_YANK_NEWEST, BYTE_W'($urandom), INDEX_W'($urandom));
	endtask

	task automatic test_random_ops();
		int pick;
		logic [OP_W-1:0] op;
		repeat (RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) op = OP_NEW_KILL;
			else if (pick < 36) op = OP_APPEND;
			else if (pick < 56) op = OP_INSERT;
			else if (pick < 80) op = OP_READ;
			else if (pick < 85) op = OP_YANK_NEWEST;
			else if (pick < 96) op = OP_YANK_OLDER;
			else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
			send_req(op, BYTE_W'($urandom),
				(op == OP_READ) ? pick_index() : INDEX_W'($urandom));
			if ($urandom_range(0, 199) == 0)
				wait_idle();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		wait_idle();
		test_entry_fill();
		wait_idle();
		test_ring_wrap();
		wait_idle();
		test_random_ops();
		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/krbs_pkg.sv
rtl/krbs_ram.sv
rtl/krbs_meta.sv
rtl/kill_ring_byte_store.sv
tb/tb.sv
